>>> hdl/lvps_pkg.sv
// Package for the latching valve pulse sequencer: widths, phase and command
// codes, register indexes, configuration and result structures.
// Depends on nothing; every other file of the block refers to it by scope.
package lvps_pkg;

   localparam int CHANNELS    = 4;
   localparam int CH_IDX_W    = 2;
   localparam int NIBBLE_W    = 4;
   localparam int WORD_W      = 32;
   localparam int TICK_W      = 16;
   localparam int ADDR_W      = 4;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [NIBBLE_W-1:0] CH_MASK = NIBBLE_W'((1 << CHANNELS) - 1);

   localparam logic [ADDR_W-1:0] RST_NODE_ADDRESS    = 4'd1;
   localparam logic [TICK_W-1:0] RST_ON_PHASE_TICKS  = 16'd100;
   localparam logic [TICK_W-1:0] RST_OFF_PULSE_TICKS = 16'd50;
   localparam logic [TICK_W-1:0] RST_OFF_GAP_TICKS   = 16'd5;

   localparam logic CMD_TICK       = 1'b0;
   localparam logic CMD_STATE_WORD = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NODE_ADDRESS    = 4'd0,
      CSR_ON_PHASE_TICKS  = 4'd1,
      CSR_OFF_PULSE_TICKS = 4'd2,
      CSR_OFF_GAP_TICKS   = 4'd3
   } csr_index_type;

   // Four phases per channel: first pulse, first gap, second pulse, second gap.
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_PULSE_A = 3'd1,
      PH_GAP_A   = 3'd2,
      PH_PULSE_B = 3'd3,
      PH_GAP_B   = 3'd4
   } phase_type;

   typedef struct packed {
      logic [ADDR_W-1:0] node_address;
      logic [TICK_W-1:0] on_phase_ticks;
      logic [TICK_W-1:0] off_pulse_ticks;
      logic [TICK_W-1:0] off_gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic [NIBBLE_W-1:0] enable_pins;
      logic [NIBBLE_W-1:0] disable_pins;
      logic [NIBBLE_W-1:0] valve_state;
      logic                busy_res;
      logic                rejected;
      logic                persist_strobe;
      logic [NIBBLE_W-1:0] persist_value;
   } rsp_type;

   // A timing register of zero behaves as one tick.
   function automatic logic [TICK_W-1:0] load_count(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

endpackage

>>> hdl/lvps_if.sv
// Handshake channels of the latching valve pulse sequencer: request,
// response and register write. Depends on lvps_pkg for the field widths.

interface lvps_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [lvps_pkg::WORD_W-1:0]      state_word;

   modport source (output valid, command, state_word, input ready);
   modport sink   (input valid, command, state_word, output ready);
endinterface

interface lvps_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lvps_pkg::NIBBLE_W-1:0]    enable_pins;
   logic [lvps_pkg::NIBBLE_W-1:0]    disable_pins;
   logic [lvps_pkg::NIBBLE_W-1:0]    valve_state;
   logic                             busy_res;
   logic                             rejected;
   logic                             persist_strobe;
   logic [lvps_pkg::NIBBLE_W-1:0]    persist_value;

   modport source (output valid, enable_pins, disable_pins, valve_state, busy_res,
                   rejected, persist_strobe, persist_value, input ready);
   modport sink   (input valid, enable_pins, disable_pins, valve_state, busy_res,
                   rejected, persist_strobe, persist_value, output ready);
endinterface

interface lvps_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lvps_pkg::CSR_INDEX_W-1:0] index;
   logic [lvps_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/lvps_seq.sv
// Pulse sequencing core: valve state, per-channel phase machine and tick timer.
// Depends on lvps_pkg; gives the result of each request combinationally, before its state is registered.
module lvps_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          command,
   input  logic [lvps_pkg::WORD_W-1:0]   state_word,
   input  lvps_pkg::cfg_type             cfg,
   output lvps_pkg::rsp_type             result
);

   lvps_pkg::phase_type                phase_ff, phase_in;
   logic [lvps_pkg::CH_IDX_W-1:0]      active_ff, active_in;
   logic [lvps_pkg::NIBBLE_W-1:0]      target_ff, target_in;
   logic [lvps_pkg::NIBBLE_W-1:0]      pending_ff, pending_in;
   logic [lvps_pkg::NIBBLE_W-1:0]      current_ff, current_in;
   logic [lvps_pkg::TICK_W-1:0]        countdown_ff, countdown_in;

   logic                               busy;
   logic                               start;
   logic                               load;
   logic                               turn_on;
   logic                               rejected;
   logic                               strobe;
   logic [2:0]                         nibble_sel;
   logic [lvps_pkg::NIBBLE_W-1:0]      nibble;
   logic [lvps_pkg::TICK_W-1:0]        countdown_dec;
   logic [lvps_pkg::NIBBLE_W-1:0]      active_bit;
   logic [lvps_pkg::NIBBLE_W-1:0]      enable_levels;
   logic [lvps_pkg::NIBBLE_W-1:0]      disable_levels;

   always_comb begin
      busy          = (phase_ff != lvps_pkg::PH_IDLE);
      phase_in      = phase_ff;
      active_in     = active_ff;
      target_in     = target_ff;
      pending_in    = pending_ff;
      current_in    = current_ff;
      countdown_in  = countdown_ff;
      start         = 1'b0;
      load          = 1'b0;
      rejected      = 1'b0;
      strobe        = 1'b0;
      // Node n owns nibble n-1, taken modulo eight.
      nibble_sel    = cfg.node_address[2:0] - 3'd1;
      nibble        = state_word[{nibble_sel, 2'b00} +: lvps_pkg::NIBBLE_W];
      countdown_dec = countdown_ff - lvps_pkg::TICK_W'(1);

      if (command == lvps_pkg::CMD_STATE_WORD) begin
         if (busy) begin
            rejected = 1'b1;
         end else begin
            target_in  = nibble & lvps_pkg::CH_MASK;
            pending_in = (target_in ^ current_ff) & lvps_pkg::CH_MASK;
            start      = 1'b1;
         end
      end else if (busy) begin
         countdown_in = countdown_dec;
         if (countdown_dec == '0) begin
            if (phase_ff != lvps_pkg::PH_GAP_B) begin
               phase_in = lvps_pkg::phase_type'(phase_ff + 3'd1);
               load     = 1'b1;
            end else begin
               current_in[active_ff] = target_ff[active_ff];
               pending_in[active_ff] = 1'b0;
               start                 = 1'b1;
            end
         end
      end

      // Pick the lowest pending channel, or finish the sequence.
      if (start) begin
         if (pending_in != '0) begin
            for (int i = lvps_pkg::CHANNELS - 1; i >= 0; i--) begin
               if (pending_in[i]) begin
                  active_in = lvps_pkg::CH_IDX_W'(i);
               end
            end
            phase_in = lvps_pkg::PH_PULSE_A;
            load     = 1'b1;
         end else begin
            phase_in     = lvps_pkg::PH_IDLE;
            countdown_in = '0;
            strobe       = 1'b1;
         end
      end

      turn_on = target_in[active_in];
      if (load) begin
         if (turn_on) begin
            countdown_in = lvps_pkg::load_count(cfg.on_phase_ticks);
         end else if (phase_in == lvps_pkg::PH_PULSE_A || phase_in == lvps_pkg::PH_PULSE_B) begin
            countdown_in = lvps_pkg::load_count(cfg.off_pulse_ticks);
         end else begin
            countdown_in = lvps_pkg::load_count(cfg.off_gap_ticks);
         end
      end

      // Pin levels follow from the phase: turn-on drives DIS first, turn-off EN.
      active_bit     = lvps_pkg::NIBBLE_W'(1) << active_in;
      enable_levels  = '0;
      disable_levels = '0;
      if (phase_in == lvps_pkg::PH_PULSE_A) begin
         if (turn_on) disable_levels = active_bit;
         else         enable_levels  = active_bit;
      end else if (phase_in == lvps_pkg::PH_PULSE_B) begin
         if (turn_on) enable_levels  = active_bit;
         else         disable_levels = active_bit;
      end

      result.enable_pins    = enable_levels;
      result.disable_pins   = disable_levels;
      result.valve_state    = current_in;
      result.busy_res       = (phase_in != lvps_pkg::PH_IDLE);
      result.rejected       = rejected;
      result.persist_strobe = strobe;
      result.persist_value  = strobe ? target_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lvps_pkg::PH_IDLE;
         active_ff    <= '0;
         target_ff    <= '0;
         pending_ff   <= '0;
         current_ff   <= '0;
         countdown_ff <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         target_ff    <= target_in;
         pending_ff   <= pending_in;
         current_ff   <= current_in;
         countdown_ff <= countdown_in;
      end
   end

endmodule

>>> hdl/latching_valve_pulse_sequencer.sv
// Top level of the latching valve pulse sequencer: register file, response
// register and handshakes. Depends on lvps_pkg, lvps_if.sv and lvps_seq.
//
//   channel | port | direction | payload
//   --------+------+-----------+---------------------------------------------
//   request | req  | in        | command, state_word
//   result  | rsp  | out       | pins, valve_state, busy_res, rejected, persist
//   regs    | csr  | in        | index, data (always ready)
//
// The sequencing logic works combinationally between the state registers
// and the response register, so one request is taken per clock whenever
// the response register is empty or being emptied.
// A response appears on rsp the cycle after its request is accepted.
// Synchronous reset clears the valve state, the phase machine and the
// registers to their defaults; rsp is empty after reset.
// A stalled response holds, and req.ready drops until it is taken.
module latching_valve_pulse_sequencer (
   input  logic        clock,
   input  logic        reset,
   lvps_req_if.sink    req,
   lvps_rsp_if.source  rsp,
   lvps_csr_if.sink    csr
);

   lvps_pkg::cfg_type  cfg_ff;
   lvps_pkg::rsp_type  rsp_ff;
   lvps_pkg::rsp_type  rsp_in;
   logic               rsp_valid_ff;
   logic               req_accept;

   // The response register is the only stage, so a request may enter as soon
   // as the previous response leaves in the same cycle.
   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;
   assign csr.ready  = 1'b1;

   // Register writes to indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_address    <= lvps_pkg::RST_NODE_ADDRESS;
         cfg_ff.on_phase_ticks  <= lvps_pkg::RST_ON_PHASE_TICKS;
         cfg_ff.off_pulse_ticks <= lvps_pkg::RST_OFF_PULSE_TICKS;
         cfg_ff.off_gap_ticks   <= lvps_pkg::RST_OFF_GAP_TICKS;
      end else if (csr.valid) begin
         case (csr.index)
            lvps_pkg::CSR_NODE_ADDRESS: begin
               cfg_ff.node_address <= csr.data[lvps_pkg::ADDR_W-1:0];
            end
            lvps_pkg::CSR_ON_PHASE_TICKS: begin
               cfg_ff.on_phase_ticks <= csr.data[lvps_pkg::TICK_W-1:0];
            end
            lvps_pkg::CSR_OFF_PULSE_TICKS: begin
               cfg_ff.off_pulse_ticks <= csr.data[lvps_pkg::TICK_W-1:0];
            end
            lvps_pkg::CSR_OFF_GAP_TICKS: begin
               cfg_ff.off_gap_ticks <= csr.data[lvps_pkg::TICK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The core advances its state only on an accepted request and gives the
   // result of that request combinationally.
   lvps_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .command    (req.command),
      .state_word (req.state_word),
      .cfg        (cfg_ff),
      .result     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The payload needs no reset; it is loaded with every accepted request.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.enable_pins    = rsp_ff.enable_pins;
   assign rsp.disable_pins   = rsp_ff.disable_pins;
   assign rsp.valve_state    = rsp_ff.valve_state;
   assign rsp.busy_res       = rsp_ff.busy_res;
   assign rsp.rejected       = rsp_ff.rejected;
   assign rsp.persist_strobe = rsp_ff.persist_strobe;
   assign rsp.persist_value  = rsp_ff.persist_value;

`ifndef SYNTHESIS
   // A finished sequence leaves the block idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.persist_strobe |-> !rsp_ff.busy_res)
      else $error("persist strobe while still busy");

   // A dropped state word never advances timing, so the block is still busy.
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rejected |-> rsp_ff.busy_res)
      else $error("request rejected while idle");

   // At most one coil pin is driven at any time.
   a_one_pin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_ff.enable_pins, rsp_ff.disable_pins}))
      else $error("more than one coil pin driven");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the latching valve pulse sequencer: directed cases,
// random traffic under three idling profiles, back-pressure and a long timer.
// Depends on lvps_pkg, the lvps_*_if interfaces and the block's top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lvps_pkg::*;

   logic clock;
   logic reset;

   lvps_req_if req_bus ();
   lvps_rsp_if rsp_bus ();
   lvps_csr_if csr_bus ();

   latching_valve_pulse_sequencer uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // Predicted copy of the register file and of the sequencer state.  It is
   // advanced once per accepted request, at the edge that accepts it.
   cfg_type             valve_cfg;
   logic [NIBBLE_W-1:0] valves_now;
   logic [NIBBLE_W-1:0] valves_goal;
   logic [NIBBLE_W-1:0] channels_left;
   logic [CH_IDX_W-1:0] chan_sel;
   phase_type           ph;
   logic [TICK_W-1:0]   ticks_left;
   logic [NIBBLE_W-1:0] en_lv;
   logic [NIBBLE_W-1:0] dis_lv;

   // Responses still owed by the block, oldest first.
   rsp_type predicted_rsp[$];

   int error_count    = 0;
   int rsp_seen       = 0;
   int requests_taken = 0;
   int words_dropped  = 0;
   int sequences_done = 0;
   int csr_writes     = 0;

   // Idling profile, in percent, and the long receiver hold-off in cycles.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;

   // The clock has a 2 ns period; everything is driven at the falling edge
   // so that the rising edge always sees settled inputs.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Safety net: the slowest correct run is well under a fifth of this.
   initial begin
      #2_000_000;
      $display("Timeout: %0d responses still outstanding", predicted_rsp.size());
      $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic void reset_predictor();
      valve_cfg     = {RST_NODE_ADDRESS, RST_ON_PHASE_TICKS, RST_OFF_PULSE_TICKS,
                       RST_OFF_GAP_TICKS};
      valves_now    = '0;
      valves_goal   = '0;
      channels_left = '0;
      chan_sel      = '0;
      ph            = PH_IDLE;
      ticks_left    = '0;
      en_lv         = '0;
      dis_lv        = '0;
   endfunction

   // Drives the pins of the selected channel for phase p and loads the timer.
   // Opening a valve pulses DIS then EN, each phase lasting the turn-on time;
   // closing pulses EN then DIS with separate pulse and gap times.  A timing
   // register of zero still gives a phase of one tick.
   function automatic void begin_phase(input phase_type p);
      logic [NIBBLE_W-1:0] sel;
      logic [TICK_W-1:0]   len;
      sel    = NIBBLE_W'(1) << chan_sel;
      ph     = p;
      en_lv  = '0;
      dis_lv = '0;
      if (valves_goal[chan_sel]) begin
         if (p == PH_PULSE_A) dis_lv = sel;
         if (p == PH_PULSE_B) en_lv = sel;
         len = valve_cfg.on_phase_ticks;
      end else begin
         if (p == PH_PULSE_A) en_lv = sel;
         if (p == PH_PULSE_B) dis_lv = sel;
         len = (p == PH_PULSE_A || p == PH_PULSE_B) ? valve_cfg.off_pulse_ticks
                                                    : valve_cfg.off_gap_ticks;
      end
      ticks_left = (len == '0) ? TICK_W'(1) : len;
   endfunction

   // Starts the lowest channel still to be moved; with none left the
   // sequencer drops back to idle and the caller raises the persist strobe.
   function automatic bit pick_next_channel();
      for (int i = 0; i < CHANNELS; i++) begin
         if (channels_left[i]) begin
            chan_sel = CH_IDX_W'(i);
            begin_phase(PH_PULSE_A);
            return 1'b1;
         end
      end
      ph         = PH_IDLE;
      ticks_left = '0;
      en_lv      = '0;
      dis_lv     = '0;
      return 1'b0;
   endfunction

   // Applies one request to the predicted state and returns the response
   // that the block must give for it.
   function automatic rsp_type step_valves(input logic cmd,
                                           input logic [WORD_W-1:0] word);
      rsp_type             r;
      logic [2:0]          nib;
      r = '0;
      if (cmd == CMD_STATE_WORD) begin
         if (ph != PH_IDLE) begin
            // A word that arrives mid-sequence is dropped and the timer holds.
            r.rejected = 1'b1;
         end else begin
            // Node addresses outside 1..8 wrap: 0 picks the top nibble.
            nib           = 3'(valve_cfg.node_address - 4'd1);
            valves_goal   = word[{nib, 2'b00} +: NIBBLE_W] & CH_MASK;
            channels_left = (valves_goal ^ valves_now) & CH_MASK;
            if (!pick_next_channel()) begin
               r.persist_strobe = 1'b1;
               r.persist_value  = valves_goal;
            end
         end
      end else if (ph != PH_IDLE) begin
         ticks_left = ticks_left - TICK_W'(1);
         if (ticks_left == '0) begin
            if (ph != PH_GAP_B) begin
               begin_phase(phase_type'(ph + 3'd1));
            end else begin
               valves_now[chan_sel]    = valves_goal[chan_sel];
               channels_left[chan_sel] = 1'b0;
               if (!pick_next_channel()) begin
                  r.persist_strobe = 1'b1;
                  r.persist_value  = valves_goal;
               end
            end
         end
      end
      r.enable_pins  = en_lv;
      r.disable_pins = dis_lv;
      r.valve_state  = valves_now;
      r.busy_res     = (ph != PH_IDLE);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40)
         $display("[%0t] response %0d: %s", $time, rsp_seen, what);
   endtask

   task automatic check_field(input string name, input logic [NIBBLE_W-1:0] got,
                              input logic [NIBBLE_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
   endtask

   // One process watches all three channels at the rising edge.  The
   // response is checked before the request of the same edge is predicted,
   // although a response can never belong to a request taken at that edge.
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type next_rsp;
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            rsp_seen++;
            if (predicted_rsp.size() == 0) begin
               report_mismatch("response arrived with nothing predicted");
            end else begin
               want = predicted_rsp.pop_front();
               check_field("enable_pins", rsp_bus.enable_pins, want.enable_pins);
               check_field("disable_pins", rsp_bus.disable_pins, want.disable_pins);
               check_field("valve_state", rsp_bus.valve_state, want.valve_state);
               check_field("busy_res", rsp_bus.busy_res, want.busy_res);
               check_field("rejected", rsp_bus.rejected, want.rejected);
               check_field("persist_strobe", rsp_bus.persist_strobe, want.persist_strobe);
               check_field("persist_value", rsp_bus.persist_value, want.persist_value);
            end
         end
         if (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1) begin
            csr_writes++;
            case (csr_index_type'(csr_bus.index))
               CSR_NODE_ADDRESS:    valve_cfg.node_address    = csr_bus.data[ADDR_W-1:0];
               CSR_ON_PHASE_TICKS:  valve_cfg.on_phase_ticks  = csr_bus.data;
               CSR_OFF_PULSE_TICKS: valve_cfg.off_pulse_ticks = csr_bus.data;
               CSR_OFF_GAP_TICKS:   valve_cfg.off_gap_ticks   = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            next_rsp = step_valves(req_bus.command, req_bus.state_word);
            predicted_rsp.push_back(next_rsp);
            requests_taken++;
            if (next_rsp.rejected) words_dropped++;
            if (next_rsp.persist_strobe) sequences_done++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on demand.  The hold-off
   // is counted down here so the sender keeps offering requests meanwhile.
   // ------------------------------------------------------------------

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offers one request and returns at the falling edge after it is taken.
   // Valid is left high so back-to-back requests need no second assignment
   // in the same time step; it is only lowered when a gap is inserted.
   task automatic send_request(input logic cmd, input logic [WORD_W-1:0] word);
      if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99, 0) < send_idle_pct);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.state_word <= word;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Ticks any running sequence to its end, stops offering requests and
   // waits until every predicted response has been taken.
   task automatic quiesce();
      while (ph != PH_IDLE) send_request(CMD_TICK, $urandom());
      req_bus.valid <= 1'b0;
      while (predicted_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] on_ticks,
                            input logic [CSR_DATA_W-1:0] pulse_ticks,
                            input logic [CSR_DATA_W-1:0] gap_ticks);
      quiesce();
      write_reg(CSR_NODE_ADDRESS, addr);
      write_reg(CSR_ON_PHASE_TICKS, on_ticks);
      write_reg(CSR_OFF_PULSE_TICKS, pulse_ticks);
      write_reg(CSR_OFF_GAP_TICKS, gap_ticks);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset defaults: a tick while idle changes nothing, and a word that
   // matches the closed valves finishes at once with the persist strobe.
   task automatic test_idle_behaviour();
      send_request(CMD_TICK, 32'hFFFF_FFFF);
      send_request(CMD_STATE_WORD, 32'h0000_0000);
      send_request(CMD_TICK, 32'h0000_0000);
      quiesce();
   endtask

   // All timing registers at zero so every phase lasts one tick, with the
   // node address at both ends of its field so the nibble index wraps.
   task automatic test_zero_timing_and_address_wrap();
      configure(16'd0, 16'd0, 16'd0, 16'd0);
      // Address 0 selects the top nibble: open channels 1 and 4.
      send_request(CMD_STATE_WORD, 32'h9000_0000);
      send_request(CMD_TICK, 32'h0000_0000);
      send_request(CMD_TICK, 32'hFFFF_FFFF);
      // A word while busy is dropped and must not advance the timer.
      send_request(CMD_STATE_WORD, 32'hFFFF_FFFF);
      quiesce();
      // Address 15 wraps to the seventh nibble: close channel 4 only.
      configure(16'd15, 16'd0, 16'd0, 16'd0);
      send_request(CMD_STATE_WORD, 32'h0100_0000);
      quiesce();
   endtask

   // Mostly well-formed traffic: a state word whenever the sequencer is idle
   // and ticks while it is busy, with some ticks while idle and some words
   // while busy mixed in.  The registers are re-drawn every chunk with short
   // timings so that many sequences complete.
   task automatic test_random_traffic(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         if (sent % 130 == 0)
            configure($urandom_range(15, 0), $urandom_range(5, 0),
                      $urandom_range(4, 0), $urandom_range(4, 0));
         if (ph == PH_IDLE)
            send_request(($urandom_range(99, 0) < 88) ? CMD_STATE_WORD : CMD_TICK,
                         $urandom());
         else
            send_request(($urandom_range(99, 0) < 8) ? CMD_STATE_WORD : CMD_TICK,
                         $urandom());
         sent++;
      end
      quiesce();
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the response register fills and the block must stall its input.
   task automatic test_response_backpressure();
      configure(16'd3, 16'd2, 16'd1, 16'd2);
      hold_left = 80;
      repeat (40)
         send_request((ph == PH_IDLE) ? CMD_STATE_WORD : CMD_TICK, $urandom());
      quiesce();
   endtask

   // Long gap timer: open channel 1 quickly, then close it with a zero pulse
   // time, which still lasts one tick, and a gap time well beyond the others.
   task automatic test_longest_timer();
      configure(16'd8, 16'd1, 16'd1, 16'd1);
      send_request(CMD_STATE_WORD, {4'h1, 28'($urandom())});
      quiesce();
      configure(16'd8, 16'd1, 16'd0, 16'd64);
      send_request(CMD_STATE_WORD, {4'h0, 28'($urandom())});
      send_request(CMD_TICK, $urandom());
      send_request(CMD_STATE_WORD, 32'hFFFF_FFFF);
      quiesce();
   endtask

   // ------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_TICK;
      req_bus.state_word = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_NODE_ADDRESS;
      csr_bus.data       = '0;
      reset_predictor();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Sender idles rarely, receiver stalls half the time.
      send_idle_pct  = 13;
      recv_stall_pct = 50;
      test_idle_behaviour();
      test_zero_timing_and_address_wrap();
      test_random_traffic(550);

      // The other way round.
      send_idle_pct  = 50;
      recv_stall_pct = 13;
      test_random_traffic(550);

      // Full rate on both sides.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_traffic(550);
      test_response_backpressure();
      test_longest_timer();

      quiesce();
      repeat (10) @(negedge clock);
      if (predicted_rsp.size() != 0)
         report_mismatch("predicted responses never arrived");

      $display("Covered %0d requests: %0d responses, %0d busy words dropped,",
               requests_taken, rsp_seen, words_dropped);
      $display("%0d valve sequences completed, %0d register writes.",
               sequences_done, csr_writes);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
